@@ rtl/grouped_team_queue_macros.svh @@
// Assertion macros used by the team queue sequencer.
`ifndef GROUPED_TEAM_QUEUE_MACROS_SVH
`define GROUPED_TEAM_QUEUE_MACROS_SVH

`ifndef SYNTH
// Checked property, disabled while reset is asserted.
`define GTQ_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property that also holds across reset.
`define GTQ_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GTQ_ASSERT(name, clk, rst_n, prop, msg)
`define GTQ_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

@@ rtl/gtq_pkg.sv @@
// Shared constants, codes and types of the team queue.
`default_nettype none

package gtq_pkg;

    // Sizes of the queue storage.
    localparam int unsigned MAX_TEAMS  = 1024;
    localparam int unsigned POOL_CELLS = 4096;
    localparam int unsigned VALUE_BITS = 32;

    // Derived index and counter widths.
    localparam int unsigned TEAM_W  = $clog2(MAX_TEAMS);
    localparam int unsigned CELL_W  = $clog2(POOL_CELLS);
    localparam int unsigned FREE_W  = $clog2(POOL_CELLS + 1);
    localparam int unsigned ORDER_W = $clog2(MAX_TEAMS + 1);

    // Fixed port field widths.
    localparam int unsigned IN_TEAM_W = 10;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned STATUS_W  = 3;
    localparam int unsigned CFG_W     = 11;
    localparam int unsigned APB_W     = 32;
    localparam int unsigned PADDR_W   = 3;
    localparam int unsigned REG_IDX_W = PADDR_W - 2;

    // Register map.
    localparam logic [REG_IDX_W-1:0] REG_TEAM_COUNT   = 1'b0;
    localparam logic [CFG_W-1:0]     TEAM_COUNT_RESET = 11'd1024;

    // Operation codes.
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_ENQ     = 3'd0,
        ST_DEQ     = 3'd1,
        ST_FULL    = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_BADTEAM = 3'd4
    } t_status;

    // One result item from the sequencer.
    typedef struct packed {
        logic [DATA_W-1:0] value;
        t_status           status;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/gtq_ram.sv @@
// Simple dual-port synchronous RAM with a registered read.
`default_nettype none

module gtq_ram #(
    parameter int unsigned DEPTH = 2,
    parameter int unsigned WIDTH = 1,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with a registered output.
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/gtq_regs.sv @@
// APB configuration register file of the team queue.
`default_nettype none

module gtq_regs
    import gtq_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [APB_W-1:0]   pwdata,
    output logic      [APB_W-1:0]   prdata,
    output logic                    pready,
    output logic      [CFG_W-1:0]   o_team_count
);

    logic [CFG_W-1:0]     r_team_count;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    // Register write on the access phase of a write transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_team_count <= TEAM_COUNT_RESET;
        end else if (wr_en && (reg_idx == REG_TEAM_COUNT)) begin
            r_team_count <= pwdata[CFG_W-1:0];
        end
    end

    // Read data decode.
    always_comb begin
        unique case (reg_idx)
            REG_TEAM_COUNT: prdata = APB_W'(r_team_count);
            default:        prdata = '0;
        endcase
    end

    assign o_team_count = r_team_count;

endmodule

`default_nettype wire

@@ rtl/gtq_ctrl.sv @@
// Sequencer of the team queue: order ring, team table, cell pool and free stack.
`default_nettype none

`include "grouped_team_queue_macros.svh"

module gtq_ctrl
    import gtq_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [CFG_W-1:0]     i_team_count,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic                 i_kind,
    input  wire logic [IN_TEAM_W-1:0] i_team,
    input  wire logic [DATA_W-1:0]    i_value,
    output logic                      o_res_valid,
    output t_result                   o_res,
    input  wire logic                 i_res_ready
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ENQ_WR,
        S_DEQ_TEAM,
        S_DEQ_CELL,
        S_DEQ_WR,
        S_DONE
    } t_state;

    // One team table word: presence flag and the ends of the team's list.
    typedef struct packed {
        logic              present;
        logic [CELL_W-1:0] first;
        logic [CELL_W-1:0] last;
    } t_team_entry;

    // Control registers.
    t_state             r_state,     n_state;
    logic [TEAM_W-1:0]  r_clr_addr,  n_clr_addr;
    logic [TEAM_W-1:0]  r_head,      n_head;
    logic [TEAM_W-1:0]  r_tail,      n_tail;
    logic [ORDER_W-1:0] r_order_cnt, n_order_cnt;
    logic [FREE_W-1:0]  r_free_cnt,  n_free_cnt;
    logic [FREE_W-1:0]  r_free_low,  n_free_low;

    // Payload registers.
    logic [TEAM_W-1:0]     r_team,     n_team;
    logic [VALUE_BITS-1:0] r_value,    n_value;
    t_status               r_status,   n_status;
    logic [CELL_W-1:0]     r_dq_first, n_dq_first;
    logic [CELL_W-1:0]     r_dq_last,  n_dq_last;

    // Memory ports.
    logic                  team_we;
    logic [TEAM_W-1:0]     team_waddr, team_raddr;
    t_team_entry           team_wdata, team_rd;
    logic                  ring_we;
    logic [TEAM_W-1:0]     ring_rdata;
    logic                  val_we;
    logic [CELL_W-1:0]     val_waddr;
    logic [VALUE_BITS-1:0] val_rdata;
    logic                  link_we;
    logic [CELL_W-1:0]     link_waddr, link_rdata;
    logic [CELL_W-1:0]     cell_raddr;
    logic                  stk_we;
    logic [CELL_W-1:0]     stk_waddr, stk_raddr, stk_rdata;

    // Helpers.
    logic              team_ok;
    logic              stk_fresh;
    logic [CELL_W-1:0] fresh_cell;
    logic [CELL_W-1:0] enq_cell;
    logic [TEAM_W-1:0] head_next, tail_next;

    gtq_ram #(.DEPTH(MAX_TEAMS), .WIDTH(TEAM_W)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_tail),
        .i_wdata (r_team),
        .i_raddr (r_head),
        .o_rdata (ring_rdata)
    );

    gtq_ram #(.DEPTH(MAX_TEAMS), .WIDTH($bits(t_team_entry))) u_team (
        .i_clk   (i_clk),
        .i_we    (team_we),
        .i_waddr (team_waddr),
        .i_wdata (team_wdata),
        .i_raddr (team_raddr),
        .o_rdata (team_rd)
    );

    gtq_ram #(.DEPTH(POOL_CELLS), .WIDTH(VALUE_BITS)) u_value (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (r_value),
        .i_raddr (cell_raddr),
        .o_rdata (val_rdata)
    );

    gtq_ram #(.DEPTH(POOL_CELLS), .WIDTH(CELL_W)) u_link (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (enq_cell),
        .i_raddr (cell_raddr),
        .o_rdata (link_rdata)
    );

    gtq_ram #(.DEPTH(POOL_CELLS), .WIDTH(CELL_W)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (r_dq_first),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // A team number must be below both the configured count and the table size.
    assign team_ok = ({1'b0, i_team} < i_team_count) &&
                     (32'(i_team) < 32'(MAX_TEAMS));

    // Stack slots below the low-water mark were never pushed; for them the cell
    // number is computed instead of read, which puts cell 0 on top after reset.
    assign stk_raddr  = CELL_W'(r_free_cnt - FREE_W'(1));
    assign stk_fresh  = (r_free_cnt - FREE_W'(1)) < r_free_low;
    assign fresh_cell = CELL_W'(FREE_W'(POOL_CELLS) - r_free_cnt);
    assign enq_cell   = stk_fresh ? fresh_cell : stk_rdata;

    assign head_next = (r_head == TEAM_W'(MAX_TEAMS - 1)) ? '0 : r_head + TEAM_W'(1);
    assign tail_next = (r_tail == TEAM_W'(MAX_TEAMS - 1)) ? '0 : r_tail + TEAM_W'(1);

    assign o_in_stall = (r_state != S_IDLE);

    // Next state, memory accesses and result.
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_head      = r_head;
        n_tail      = r_tail;
        n_order_cnt = r_order_cnt;
        n_free_cnt  = r_free_cnt;
        n_free_low  = r_free_low;
        n_team      = r_team;
        n_value     = r_value;
        n_status    = r_status;
        n_dq_first  = r_dq_first;
        n_dq_last   = r_dq_last;

        team_we    = 1'b0;
        team_waddr = r_team;
        team_wdata = '0;
        team_raddr = r_team;
        ring_we    = 1'b0;
        val_we     = 1'b0;
        val_waddr  = enq_cell;
        link_we    = 1'b0;
        link_waddr = team_rd.last;
        cell_raddr = r_dq_first;
        stk_we     = 1'b0;
        stk_waddr  = CELL_W'(r_free_cnt);

        o_res_valid  = 1'b0;
        o_res.value  = '0;
        o_res.status = r_status;

        unique case (r_state)
            // Sweep the team table to clear every presence flag.
            S_CLEAR: begin
                team_we    = 1'b1;
                team_waddr = r_clr_addr;
                team_wdata = '0;
                n_clr_addr = r_clr_addr + TEAM_W'(1);
                if (r_clr_addr == TEAM_W'(MAX_TEAMS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            // Take an item, check it and launch the first reads.
            S_IDLE: begin
                team_raddr = TEAM_W'(i_team);
                if (i_in_valid) begin
                    n_team  = TEAM_W'(i_team);
                    n_value = VALUE_BITS'(i_value);
                    if (i_kind == KIND_ENQ) begin
                        if (!team_ok) begin
                            n_status = ST_BADTEAM;
                            n_state  = S_DONE;
                        end else if (r_free_cnt == '0) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_ENQ_WR;
                        end
                    end else begin
                        if (r_order_cnt == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_DEQ_TEAM;
                        end
                    end
                end
            end
            // Pop a free cell, store the value; link it or queue a new team.
            S_ENQ_WR: begin
                o_res_valid  = 1'b1;
                o_res.status = ST_ENQ;
                if (i_res_ready) begin
                    val_we     = 1'b1;
                    team_we    = 1'b1;
                    n_free_cnt = r_free_cnt - FREE_W'(1);
                    if (team_rd.present) begin
                        link_we    = 1'b1;
                        team_wdata = '{present: 1'b1, first: team_rd.first, last: enq_cell};
                    end else begin
                        ring_we     = 1'b1;
                        team_wdata  = '{present: 1'b1, first: enq_cell, last: enq_cell};
                        n_tail      = tail_next;
                        n_order_cnt = r_order_cnt + ORDER_W'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            // The head team is known; read its table entry.
            S_DEQ_TEAM: begin
                team_raddr = ring_rdata;
                n_team     = ring_rdata;
                n_state    = S_DEQ_CELL;
            end
            // The list ends are known; read the front cell.
            S_DEQ_CELL: begin
                cell_raddr = team_rd.first;
                n_dq_first = team_rd.first;
                n_dq_last  = team_rd.last;
                n_state    = S_DEQ_WR;
            end
            // Return the front cell to the free stack and advance the team.
            S_DEQ_WR: begin
                o_res_valid  = 1'b1;
                o_res.status = ST_DEQ;
                o_res.value  = DATA_W'(val_rdata);
                if (i_res_ready) begin
                    if (r_free_cnt < FREE_W'(POOL_CELLS)) begin
                        stk_we     = 1'b1;
                        n_free_cnt = r_free_cnt + FREE_W'(1);
                        if (r_free_cnt < r_free_low) begin
                            n_free_low = r_free_cnt;
                        end
                    end
                    team_we = 1'b1;
                    if (r_dq_first == r_dq_last) begin
                        team_wdata  = '{present: 1'b0, first: r_dq_first, last: r_dq_last};
                        n_head      = head_next;
                        n_order_cnt = r_order_cnt - ORDER_W'(1);
                    end else begin
                        team_wdata = '{present: 1'b1, first: link_rdata, last: r_dq_last};
                    end
                    n_state = S_IDLE;
                end
            end
            // Rejected item: report its status only.
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registers.
    always_ff @(posedge i_clk) begin
        r_team     <= n_team;
        r_value    <= n_value;
        r_status   <= n_status;
        r_dq_first <= n_dq_first;
        r_dq_last  <= n_dq_last;
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_order_cnt <= '0;
            r_free_cnt  <= FREE_W'(POOL_CELLS);
            r_free_low  <= FREE_W'(POOL_CELLS);
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_order_cnt <= n_order_cnt;
            r_free_cnt  <= n_free_cnt;
            r_free_low  <= n_free_low;
        end
    end

    // Reset always restarts the team table sweep.
    `GTQ_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (r_state == S_CLEAR), "no clear after reset")
    // A result is offered only from a finishing state.
    `GTQ_ASSERT(a_res_state, i_clk, i_rst_n, o_res_valid |-> (r_state == S_ENQ_WR || r_state == S_DEQ_WR || r_state == S_DONE), "result outside a finishing state")
    // A completed enqueue consumes exactly one free cell.
    `GTQ_ASSERT(a_enq_cell, i_clk, i_rst_n, (o_res_valid && i_res_ready && o_res.status == ST_ENQ) |=> (r_free_cnt == $past(r_free_cnt) - FREE_W'(1)), "enqueue did not take one cell")
    // An empty order ring has its pointers together.
    `GTQ_ASSERT(a_ring_empty, i_clk, i_rst_n, (r_order_cnt == '0) |-> (r_head == r_tail), "empty ring with apart pointers")

endmodule

`default_nettype wire

@@ rtl/grouped_team_queue.sv @@
// Top level of the team queue: configuration port, sequencer and output register.
//
// Channel  Handshake                    Payload
// in       i_in_valid / o_in_stall      i_kind, i_team, i_value
// out      o_out_valid / i_out_stall    o_value_out, o_status
// cfg      psel, penable, pwrite        paddr, pwdata, prdata (pready tied high)
//
// One item is in work at a time. From transfer to result: an enqueue reads the team
// entry and the free stack, then writes back; a dequeue reads the order ring, the team
// entry and the front cell one after another, each through a registered RAM read, then
// writes back; a rejected item goes straight to its report.
// After reset a sweep clears all 1024 team table entries; inputs stall until it ends.
// A held result in the output register blocks only the final write-back or report step.
`default_nettype none

module grouped_team_queue
    import gtq_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic                 i_kind,
    input  wire logic [IN_TEAM_W-1:0] i_team,
    input  wire logic [DATA_W-1:0]    i_value,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic      [DATA_W-1:0]    o_value_out,
    output logic      [STATUS_W-1:0]  o_status,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [APB_W-1:0]     pwdata,
    output logic      [APB_W-1:0]     prdata,
    output logic                      pready
);

    logic [CFG_W-1:0] team_count;
    logic             res_valid;
    logic             res_ready;
    t_result          res;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_value;
    t_status           r_out_status;

    gtq_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_team_count (team_count)
    );

    gtq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_team_count (team_count),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_team       (i_team),
        .i_value      (i_value),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_ready  (res_ready)
    );

    // The output register can take a result when empty or being drained.
    assign res_ready = !r_out_valid || !i_out_stall;

    // Output register.
    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out_value  <= res.value;
            r_out_status <= res.status;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value_out = r_out_value;
    assign o_status    = r_out_status;

endmodule

`default_nettype wire
